// ===== rtl/swa_pkg.sv =====
// Package: word types, widths and codes for the swept box collision test.
package swa_pkg;

    localparam int COORD_BITS     = 20;
    localparam int TIME_FRAC_BITS = 16;
    localparam int NUM_BITS       = COORD_BITS + 2;  // signed distances
    localparam int DEN_BITS       = COORD_BITS;      // displacement magnitude
    localparam int QUO_BITS       = TIME_FRAC_BITS + 1;

    localparam logic [1:0] KIND_NINF = 2'd0;
    localparam logic [1:0] KIND_FIN  = 2'd1;
    localparam logic [1:0] KIND_PINF = 2'd2;

    localparam logic [1:0] FACE_NONE = 2'd0;
    localparam logic [1:0] FACE_LO   = 2'd1;  // left or top face
    localparam logic [1:0] FACE_HI   = 2'd2;  // right or bottom face

    typedef struct packed {
        logic signed [COORD_BITS-1:0] moving_left;
        logic signed [COORD_BITS-1:0] moving_top;
        logic signed [COORD_BITS-1:0] moving_right;
        logic signed [COORD_BITS-1:0] moving_bottom;
        logic signed [COORD_BITS-1:0] move_x;
        logic signed [COORD_BITS-1:0] move_y;
        logic signed [COORD_BITS-1:0] static_left;
        logic signed [COORD_BITS-1:0] static_top;
        logic signed [COORD_BITS-1:0] static_right;
        logic signed [COORD_BITS-1:0] static_bottom;
    } in_word_t;

    typedef struct packed {
        logic                hit;
        logic [QUO_BITS-1:0] hit_time;
        logic [1:0]          face_x;
        logic [1:0]          face_y;
    } out_word_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [NUM_BITS-1:0] n;
        logic [DEN_BITS-1:0]        d;
    } span_t;

    // result fields that ride alongside the divider
    typedef struct packed {
        logic       hit;
        logic [1:0] face_x;
        logic [1:0] face_y;
    } side_t;

endpackage

// ===== rtl/swa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, numerator not above denominator.
module swa_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [swa_pkg::DEN_BITS-1:0] num,
    input  logic [swa_pkg::DEN_BITS-1:0] den,
    input  swa_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [swa_pkg::QUO_BITS-1:0] quo,
    output swa_pkg::side_t               out_side
);
    import swa_pkg::*;

    logic [DEN_BITS:0]   rem_reg  [QUO_BITS];
    logic [DEN_BITS-1:0] den_reg  [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg  [QUO_BITS];
    side_t               side_reg [QUO_BITS];
    logic [QUO_BITS-1:0] v_reg;

    logic [DEN_BITS:0]   rem_next [QUO_BITS];
    logic [QUO_BITS-1:0] quo_next [QUO_BITS];

    always_comb begin
        logic [DEN_BITS:0] r;
        logic [DEN_BITS:0] dd;
        logic              b;
        for (int i = 0; i < QUO_BITS; i++) begin
            if (i == 0) begin
                r  = {1'b0, num};
                dd = {1'b0, den};
            end else begin
                r  = {rem_reg[i-1][DEN_BITS-1:0], 1'b0};
                dd = {1'b0, den_reg[i-1]};
            end
            b           = (r >= dd);
            rem_next[i] = b ? r - dd : r;
            if (i == 0) begin
                quo_next[i] = {{(QUO_BITS-1){1'b0}}, b};
            end else begin
                quo_next[i] = {quo_reg[i-1][QUO_BITS-2:0], b};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[QUO_BITS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < QUO_BITS; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                if (i == 0) begin
                    den_reg[i]  <= den;
                    side_reg[i] <= in_side;
                end else begin
                    den_reg[i]  <= den_reg[i-1];
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    end

    assign out_valid = v_reg[QUO_BITS-1];
    assign quo       = quo_reg[QUO_BITS-1];
    assign out_side  = side_reg[QUO_BITS-1];

endmodule

// ===== rtl/swept_aabb_collision.sv =====
// Top level of the swept box collision test: decision pipeline feeding the time divider.
//
// One box pair enters on the s_ channel as an in_word_t word (s_valid/s_ready);
// one result word leaves on the m_ channel (m_valid/m_ready) for every pair.
// Words flow in order, one per cycle when the receiver keeps m_ready high.
// The pipeline has 23 register stages: an input register, five decision stages (setup,
// two rounds of cross-multiplied time compares, final check) and a 17-stage
// divider that yields one bit of the Q1.16 entry time per stage.
// Throughput is one word per cycle while the receiver does not stall; most of the depth is the divider.
// The whole pipeline advances together whenever the last stage is empty or
// being taken; when the receiver stalls with a result waiting, every stage
// holds and s_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the block then accepts a word at once.
// A miss returns hit, hit_time and both faces as zero; an overlap returns a
// hit at time zero with no face.
module swept_aabb_collision (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  swa_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output swa_pkg::out_word_t m_data
);
    import swa_pkg::*;

    localparam int PW = NUM_BITS + DEN_BITS + 1;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ordering of two span times given the product compare
    function automatic logic [1:0] ord(input logic [1:0] ka, input logic [1:0] kb,
                                       input logic lt, input logic gt);
        logic [1:0] r;
        r = ORD_EQ;
        if (ka != KIND_FIN || kb != KIND_FIN) begin
            if (ka < kb) begin
                r = ORD_LT;
            end else if (ka > kb) begin
                r = ORD_GT;
            end
        end else if (lt) begin
            r = ORD_LT;
        end else if (gt) begin
            r = ORD_GT;
        end
        return r;
    endfunction

    // stage 0: input register
    logic     v0_reg;
    in_word_t in_reg;

    // stage 1
    logic  v1_reg, ovl1_reg, miss1_reg, dxp1_reg, dyp1_reg;
    span_t txe1_reg, txx1_reg, tye1_reg, tyx1_reg;

    // stage 2
    logic                 v2_reg, ovl2_reg, miss2_reg, dxp2_reg, dyp2_reg;
    span_t                txe2_reg, txx2_reg, tye2_reg, tyx2_reg;
    logic signed [PW-1:0] pa2_reg, pb2_reg, pc2_reg, pd2_reg;

    // stage 3
    logic       v3_reg, ovl3_reg, miss3_reg;
    span_t      te3_reg, tx3_reg;
    logic [1:0] fx3_reg, fy3_reg;

    // stage 4
    logic                 v4_reg, ovl4_reg, miss4_reg;
    span_t                te4_reg;
    logic [1:0]           kx4_reg, fx4_reg, fy4_reg;
    logic signed [PW-1:0] pe4_reg, pf4_reg;

    // stage 5
    logic                v5_reg;
    logic [DEN_BITS-1:0] num5_reg, den5_reg;
    side_t               side5_reg;

    // ---- stage 1 logic
    logic signed [NUM_BITS-1:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
    logic signed [NUM_BITS-1:0] exl, exr, ext, exb;
    logic signed [NUM_BITS-1:0] dxe, dxx, dye, dyx, ndx, ndy;
    logic                       ovl1_next, miss1_next;
    span_t                      txe1_next, txx1_next, tye1_next, tyx1_next;

    always_comb begin
        ml = NUM_BITS'(in_reg.moving_left);
        mt = NUM_BITS'(in_reg.moving_top);
        mr = NUM_BITS'(in_reg.moving_right);
        mb = NUM_BITS'(in_reg.moving_bottom);
        dx = NUM_BITS'(in_reg.move_x);
        dy = NUM_BITS'(in_reg.move_y);
        sl = NUM_BITS'(in_reg.static_left);
        st = NUM_BITS'(in_reg.static_top);
        sr = NUM_BITS'(in_reg.static_right);
        sb = NUM_BITS'(in_reg.static_bottom);

        ovl1_next = (ml < sr) && (mr > sl) && (mt < sb) && (mb > st);

        exl = (dx > 0) ? ml : ml + dx;
        exr = (dx > 0) ? mr + dx : mr;
        ext = (dy > 0) ? mt : mt + dy;
        exb = (dy > 0) ? mb + dy : mb;
        miss1_next = (dx == 0 && dy == 0) ||
                     (exr < sl) || (exl > sr) || (exb < st) || (ext > sb);

        dxe = (dx > 0) ? sl - mr : sr - ml;
        dxx = (dx > 0) ? sr - ml : sl - mr;
        dye = (dy > 0) ? st - mb : sb - mt;
        dyx = (dy > 0) ? sb - mt : st - mb;
        ndx = -dx;
        ndy = -dy;

        txe1_next.kind = KIND_FIN;
        txx1_next.kind = KIND_FIN;
        tye1_next.kind = KIND_FIN;
        tyx1_next.kind = KIND_FIN;
        if (dx == 0) begin
            txe1_next = '{KIND_NINF, '0, DEN_BITS'(1)};
            txx1_next = '{KIND_PINF, '0, DEN_BITS'(1)};
        end else if (dx < 0) begin
            txe1_next.n = -dxe;
            txx1_next.n = -dxx;
            txe1_next.d = ndx[DEN_BITS-1:0];
            txx1_next.d = ndx[DEN_BITS-1:0];
        end else begin
            txe1_next.n = dxe;
            txx1_next.n = dxx;
            txe1_next.d = dx[DEN_BITS-1:0];
            txx1_next.d = dx[DEN_BITS-1:0];
        end
        if (dy == 0) begin
            tye1_next = '{KIND_NINF, '0, DEN_BITS'(1)};
            tyx1_next = '{KIND_PINF, '0, DEN_BITS'(1)};
        end else if (dy < 0) begin
            tye1_next.n = -dye;
            tyx1_next.n = -dyx;
            tye1_next.d = ndy[DEN_BITS-1:0];
            tyx1_next.d = ndy[DEN_BITS-1:0];
        end else begin
            tye1_next.n = dye;
            tyx1_next.n = dyx;
            tye1_next.d = dy[DEN_BITS-1:0];
            tyx1_next.d = dy[DEN_BITS-1:0];
        end
    end

    // ---- stage 2 logic: window checks and first cross products
    logic win2_next;
    logic signed [PW-1:0] pa2_next, pb2_next, pc2_next, pd2_next;

    function automatic logic is_neg(input span_t t);
        return (t.kind == KIND_NINF) || (t.kind == KIND_FIN && t.n < 0);
    endfunction

    function automatic logic above_one(input span_t t);
        return (t.kind == KIND_PINF) ||
               (t.kind == KIND_FIN && t.n > $signed({2'b00, t.d}));
    endfunction

    function automatic logic signed [PW-1:0] xmul(input logic signed [NUM_BITS-1:0] n,
                                                 input logic [DEN_BITS-1:0] d);
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
        a = PW'(n);
        b = $signed({{(PW-DEN_BITS){1'b0}}, d});
        return a * b;
    endfunction

    always_comb begin
        win2_next = (is_neg(txe1_reg) && is_neg(tye1_reg)) ||
                    above_one(txe1_reg) || above_one(tye1_reg);
        pa2_next  = xmul(txe1_reg.n, tye1_reg.d);
        pb2_next  = xmul(tye1_reg.n, txe1_reg.d);
        pc2_next  = xmul(txx1_reg.n, tyx1_reg.d);
        pd2_next  = xmul(tyx1_reg.n, txx1_reg.d);
    end

    // ---- stage 3 logic: pick latest entry, earliest exit, face
    logic [1:0] oe, ox;
    span_t      te3_next, tx3_next;
    logic [1:0] fx3_next, fy3_next;

    always_comb begin
        oe = ord(txe2_reg.kind, tye2_reg.kind, pa2_reg < pb2_reg, pa2_reg > pb2_reg);
        ox = ord(txx2_reg.kind, tyx2_reg.kind, pc2_reg < pd2_reg, pc2_reg > pd2_reg);
        te3_next = (oe != ORD_LT) ? txe2_reg : tye2_reg;
        tx3_next = (ox != ORD_GT) ? txx2_reg : tyx2_reg;
        fx3_next = FACE_NONE;
        fy3_next = FACE_NONE;
        if (oe == ORD_GT) begin
            fx3_next = dxp2_reg ? FACE_LO : FACE_HI;
        end else begin
            fy3_next = dyp2_reg ? FACE_LO : FACE_HI;
        end
    end

    // ---- stage 4 logic: products for entry against exit
    logic signed [PW-1:0] pe4_next, pf4_next;
    assign pe4_next = xmul(te3_reg.n, tx3_reg.d);
    assign pf4_next = xmul(tx3_reg.n, te3_reg.d);

    // ---- stage 5 logic: final decision, set up the divide
    logic [1:0]          ot;
    logic                ok5;
    logic [DEN_BITS-1:0] num5_next, den5_next;
    side_t               side5_next;

    always_comb begin
        ot  = ord(te4_reg.kind, kx4_reg, pe4_reg < pf4_reg, pe4_reg > pf4_reg);
        ok5 = !ovl4_reg && !miss4_reg && (ot != ORD_GT) &&
              (te4_reg.kind == KIND_FIN) && (te4_reg.n >= 0);
        num5_next       = ok5 ? te4_reg.n[DEN_BITS-1:0] : '0;
        den5_next       = ok5 ? te4_reg.d : DEN_BITS'(1);
        side5_next.hit    = ovl4_reg || ok5;
        side5_next.face_x = ok5 ? fx4_reg : FACE_NONE;
        side5_next.face_y = ok5 ? fy4_reg : FACE_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg    <= s_data;

            ovl1_reg  <= ovl1_next;
            miss1_reg <= miss1_next;
            dxp1_reg  <= (NUM_BITS'(in_reg.move_x) > 0);
            dyp1_reg  <= (NUM_BITS'(in_reg.move_y) > 0);
            txe1_reg  <= txe1_next;
            txx1_reg  <= txx1_next;
            tye1_reg  <= tye1_next;
            tyx1_reg  <= tyx1_next;

            ovl2_reg  <= ovl1_reg;
            miss2_reg <= miss1_reg || win2_next;
            dxp2_reg  <= dxp1_reg;
            dyp2_reg  <= dyp1_reg;
            txe2_reg  <= txe1_reg;
            txx2_reg  <= txx1_reg;
            tye2_reg  <= tye1_reg;
            tyx2_reg  <= tyx1_reg;
            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            pc2_reg   <= pc2_next;
            pd2_reg   <= pd2_next;

            ovl3_reg  <= ovl2_reg;
            miss3_reg <= miss2_reg;
            te3_reg   <= te3_next;
            tx3_reg   <= tx3_next;
            fx3_reg   <= fx3_next;
            fy3_reg   <= fy3_next;

            ovl4_reg  <= ovl3_reg;
            miss4_reg <= miss3_reg;
            te4_reg   <= te3_reg;
            kx4_reg   <= tx3_reg.kind;
            fx4_reg   <= fx3_reg;
            fy4_reg   <= fy3_reg;
            pe4_reg   <= pe4_next;
            pf4_reg   <= pf4_next;

            num5_reg  <= num5_next;
            den5_reg  <= den5_next;
            side5_reg <= side5_next;
        end
    end

    logic                div_valid;
    logic [QUO_BITS-1:0] div_quo;
    side_t               div_side;

    swa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .num       (num5_reg),
        .den       (den5_reg),
        .in_side   (side5_reg),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side)
    );

    assign m_valid         = div_valid;
    assign m_data.hit      = div_side.hit;
    assign m_data.hit_time = div_quo;
    assign m_data.face_x   = div_side.face_x;
    assign m_data.face_y   = div_side.face_y;

endmodule

// ===== tb/swept_aabb_collision_checker.sv =====
// Checker: watches both channels, predicts each swept box result and compares.
module swept_aabb_collision_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  swa_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  swa_pkg::out_word_t m_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import swa_pkg::*;

    typedef struct {
        int      kind;   // -1 minus infinity, 0 finite, +1 plus infinity
        longint  n;
        longint  d;
    } sweep_time_t;

    out_word_t result_q[$];

    assign pending = result_q.size();

    function automatic sweep_time_t entry_exit(longint gap, longint disp, int inf_kind);
        sweep_time_t t;
        t.kind = 0;
        t.n = gap;
        t.d = disp;
        if (disp == 0) begin
            t.kind = inf_kind;
            t.n = 0;
            t.d = 1;
        end else if (disp < 0) begin
            t.n = -gap;
            t.d = -disp;
        end
        return t;
    endfunction

    // products stay below 2^45, so longint is exact
    function automatic int order(sweep_time_t a, sweep_time_t b);
        longint l, r;
        if (a.kind != 0 || b.kind != 0) begin
            if (a.kind == b.kind) return 0;
            return a.kind < b.kind ? -1 : 1;
        end
        l = a.n * b.d;
        r = b.n * a.d;
        return l < r ? -1 : (l > r ? 1 : 0);
    endfunction

    function automatic out_word_t predict_contact(in_word_t w);
        out_word_t o;
        longint ml, mt, mr, mb, dx, dy, sl, st, sr, sb, exl, exr, ext, exb;
        sweep_time_t txe, txx, tye, tyx, te, tx;
        bit neg_x, neg_y, big_x, big_y;
        o = '0;
        ml = w.moving_left;  mt = w.moving_top;
        mr = w.moving_right; mb = w.moving_bottom;
        dx = w.move_x;       dy = w.move_y;
        sl = w.static_left;  st = w.static_top;
        sr = w.static_right; sb = w.static_bottom;
        if (ml < sr && mr > sl && mt < sb && mb > st) begin
            o.hit = 1'b1;
            return o;
        end
        if (dx == 0 && dy == 0) return o;
        exl = dx > 0 ? ml : ml + dx;
        exr = dx > 0 ? mr + dx : mr;
        ext = dy > 0 ? mt : mt + dy;
        exb = dy > 0 ? mb + dy : mb;
        if (exr < sl || exl > sr || exb < st || ext > sb) return o;
        txe = entry_exit(dx > 0 ? sl - mr : sr - ml, dx, -1);
        txx = entry_exit(dx > 0 ? sr - ml : sl - mr, dx, 1);
        tye = entry_exit(dy > 0 ? st - mb : sb - mt, dy, -1);
        tyx = entry_exit(dy > 0 ? sb - mt : st - mb, dy, 1);
        neg_x = txe.kind < 0 || (txe.kind == 0 && txe.n < 0);
        neg_y = tye.kind < 0 || (tye.kind == 0 && tye.n < 0);
        big_x = txe.kind > 0 || (txe.kind == 0 && txe.n > txe.d);
        big_y = tye.kind > 0 || (tye.kind == 0 && tye.n > tye.d);
        if ((neg_x && neg_y) || big_x || big_y) return o;
        te = order(txe, tye) >= 0 ? txe : tye;
        tx = order(txx, tyx) <= 0 ? txx : tyx;
        if (order(te, tx) > 0) return o;
        if (te.kind != 0 || te.n < 0 || te.d <= 0) return o;
        o.hit = 1'b1;
        o.hit_time = QUO_BITS'((te.n <<< TIME_FRAC_BITS) / te.d);
        if (order(txe, tye) > 0)
            o.face_x = dx > 0 ? FACE_LO : FACE_HI;
        else
            o.face_y = dy > 0 ? FACE_LO : FACE_HI;
        return o;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want.hit !== m_data.hit || want.hit_time !== m_data.hit_time
                        || want.face_x !== m_data.face_x
                        || want.face_y !== m_data.face_y) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) result_q = {result_q, predict_contact(s_data)};
        end
    end
endmodule

// ===== tb/tb_swept_aabb_collision.sv =====
// Testbench top: drives box pairs and receiver stalls, and gives the verdict.
module tb_swept_aabb_collision;
    timeunit 1ns;
    timeprecision 1ps;
    import swa_pkg::*;

    localparam int RANDOM_PAIRS = 1630;
    localparam int IDLE_LIMIT   = 2000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    bit        calm = 1'b0;   // stretch with no idling on either side

    in_word_t  pairs[$];

    swept_aabb_collision uut (.*);

    swept_aabb_collision_checker chk (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic in_word_t box_pair(int l, int t, int r, int b, int vx, int vy,
                                          int sl, int st, int sr, int sb);
        in_word_t w;
        w.moving_left   = COORD_BITS'(l);
        w.moving_top    = COORD_BITS'(t);
        w.moving_right  = COORD_BITS'(r);
        w.moving_bottom = COORD_BITS'(b);
        w.move_x        = COORD_BITS'(vx);
        w.move_y        = COORD_BITS'(vy);
        w.static_left   = COORD_BITS'(sl);
        w.static_top    = COORD_BITS'(st);
        w.static_right  = COORD_BITS'(sr);
        w.static_bottom = COORD_BITS'(sb);
        return w;
    endfunction

    task automatic queue_pair(in_word_t w);
        pairs = {pairs, w};
    endtask

    function automatic int small_coord();
        return $signed($urandom_range(0, 1023)) - 512;
    endfunction

    // mostly pairs that can meet within the frame, some raw noise
    function automatic in_word_t random_pair();
        in_word_t w;
        int l, t, sl, st, kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            for (int i = 0; i < 10; i++) w[i*20 +: 20] = 20'($urandom());
            return w;
        end
        l = small_coord(); t = small_coord(); sl = small_coord(); st = small_coord();
        w = box_pair(l, t, l + $urandom_range(0, 200), t + $urandom_range(0, 200),
                     small_coord() * ($urandom_range(0, 3) == 0 ? 0 : 2),
                     small_coord() * ($urandom_range(0, 3) == 0 ? 0 : 2),
                     sl, st, sl + $urandom_range(0, 200), st + $urandom_range(0, 200));
        if (kind == 1) begin
            w.move_x = COORD_BITS'(sl - w.moving_right);   // exact edge contact on x
        end else if (kind == 2) begin
            w.move_x = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
            w.move_y = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
        end
        return w;
    endfunction

    // hold valid from one word to the next; drop it only while idling
    task automatic send_pair(in_word_t w, bit may_idle);
        while (may_idle && !calm && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        if (aresetn) m_ready <= calm || $urandom_range(0, 99) >= 20;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        queue_pair(box_pair(0, 0, 16, 16, 0, 0, 8, 8, 24, 24));        // overlap
        queue_pair(box_pair(0, 0, 16, 16, 0, 0, 100, 0, 120, 16));     // still, apart
        queue_pair(box_pair(0, 0, 16, 16, 64, 0, 32, 0, 48, 16));      // right, left face
        queue_pair(box_pair(64, 0, 80, 16, -64, 0, 32, 0, 48, 16));    // left
        queue_pair(box_pair(0, 0, 16, 16, 0, 64, 0, 32, 16, 48));      // down
        queue_pair(box_pair(0, 64, 16, 80, 0, -64, 0, 32, 16, 48));    // up
        queue_pair(box_pair(0, 0, 16, 16, 32, 32, 32, 32, 48, 48));    // corner tie
        queue_pair(box_pair(0, 0, 16, 16, 16, 0, 32, 0, 48, 16));      // t = 1
        queue_pair(box_pair(0, 0, 16, 16, 8, 0, 32, 0, 48, 16));       // too short
        queue_pair(box_pair(0, 0, 16, 16, 64, 0, 32, 100, 48, 116));   // broad miss
        queue_pair(box_pair(0, 0, 16, 16, 0, 64, 16, 32, 32, 48));     // edge touch
        queue_pair(box_pair(0, 0, 16, 16, 48, 3, 32, 0, 48, 16));      // odd time
        queue_pair(box_pair(16, 0, 32, 16, 64, 0, 0, 0, 16, 16));      // leaving
        queue_pair(box_pair(-524288, -524288, -524272, -524272, 524287, 524287,
                            524270, 524270, 524287, 524287));
        queue_pair(box_pair(524287, 524287, 524287, 524287, -524288, -524288,
                            -524288, -524288, -524288, -524288));
        queue_pair(box_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        queue_pair(box_pair(0, 0, 16, 16, 1, 0, 16, 0, 32, 16));
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (pairs[i]) send_pair(pairs[i], 1'b1);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            calm <= (i >= 600 && i < 800);
            send_pair(random_pair(), 1'b1);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
